[src/pll_divider_search_assert.svh]
// ----------------------------------------------------------------------------
// pll_divider_search_assert.svh
// Assertion macros used by the checker file of the divider search block.
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define PDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked while the antecedent holds.
`define PDS_ASSERT_IMP(label, ante, cons, msg) \
  `PDS_ASSERT(label, (ante) |-> (cons), msg)

`endif

[src/pds_pkg.sv]
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, constants and helpers of the PLL divider search block.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int REQ_W  = 20;  // request width
  localparam int FREQ_W = 18;  // window and VCO register width
  localparam int REF_W  = 16;  // reference clock width
  localparam int NUM_W  = 23;  // width of ref * (N + 1)
  localparam int CFG_W  = 18;  // configuration data width
  localparam int ADDR_W = 3;

  localparam int N_W = 7;
  localparam int M_W = 5;
  localparam int P_W = 2;
  localparam int D_W = 6;      // divisor M + 1

  localparam logic [N_W-1:0] N_FIRST = 7'd100;
  localparam logic [N_W-1:0] N_LAST  = 7'd127;
  localparam logic [M_W-1:0] M_LAST  = 5'd31;
  localparam logic [P_W-1:0] P_LAST  = 2'd3;

  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [FREQ_W-1:0] BAND1_KHZ = 18'd100000;
  localparam logic [FREQ_W-1:0] BAND2_KHZ = 18'd140000;
  localparam logic [FREQ_W-1:0] BAND3_KHZ = 18'd180000;

  localparam logic [REF_W-1:0]  REF_RESET     = 16'd14318;
  localparam logic [FREQ_W-1:0] VCO_MIN_RESET = 18'd50000;
  localparam logic [FREQ_W-1:0] VCO_MAX_RESET = 18'd220000;
  localparam logic [FREQ_W-1:0] OUT_MIN_RESET = 18'd6262;
  localparam logic [FREQ_W-1:0] OUT_MAX_RESET = 18'd218864;

  localparam logic [ADDR_W-1:0] CFG_REF_CLOCK = 3'd0;
  localparam logic [ADDR_W-1:0] CFG_VCO_MIN   = 3'd1;
  localparam logic [ADDR_W-1:0] CFG_VCO_MAX   = 3'd2;
  localparam logic [ADDR_W-1:0] CFG_OUT_MIN   = 3'd3;
  localparam logic [ADDR_W-1:0] CFG_OUT_MAX   = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [REF_W-1:0]  ref_clock;
    logic [FREQ_W-1:0] vco_min;
    logic [FREQ_W-1:0] vco_max;
    logic [FREQ_W-1:0] out_min;
    logic [FREQ_W-1:0] out_max;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic logic [1:0] band_of(input logic [FREQ_W-1:0] vco);
    logic [1:0] band;
    if (vco <= BAND1_KHZ) begin
      band = 2'd0;
    end else if (vco <= BAND2_KHZ) begin
      band = 2'd1;
    end else if (vco <= BAND3_KHZ) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
    return band;
  endfunction

endpackage

[src/pds_front.sv]
// ----------------------------------------------------------------------------
// pds_front
// Configuration registers, request clamping and queue push.
// ----------------------------------------------------------------------------
module pds_front import pds_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ADDR_W-1:0]        cfg_addr_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     start_i,
  input  logic [REQ_W-1:0]         request_khz_i,
  input  queue_status_t            q_status_i,
  output cfg_t                     cfg_o,
  output logic                     push_o,
  output logic [FREQ_W-1:0]        push_data_o
);

  cfg_t cfg_q, cfg_d;
  logic [REQ_W-1:0] raised;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_REF_CLOCK: cfg_d.ref_clock = cfg_wdata_i[REF_W-1:0];
        CFG_VCO_MIN:   cfg_d.vco_min   = cfg_wdata_i[FREQ_W-1:0];
        CFG_VCO_MAX:   cfg_d.vco_max   = cfg_wdata_i[FREQ_W-1:0];
        CFG_OUT_MIN:   cfg_d.out_min   = cfg_wdata_i[FREQ_W-1:0];
        CFG_OUT_MAX:   cfg_d.out_max   = cfg_wdata_i[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{REF_RESET, VCO_MIN_RESET, VCO_MAX_RESET, OUT_MIN_RESET, OUT_MAX_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Raise to the lower bound first, then cut to the upper one; a crossed
  // window therefore ends at the upper bound.
  assign raised = (request_khz_i < {{(REQ_W-FREQ_W){1'b0}}, cfg_q.out_min})
                ? {{(REQ_W-FREQ_W){1'b0}}, cfg_q.out_min} : request_khz_i;
  assign push_data_o = (raised > {{(REQ_W-FREQ_W){1'b0}}, cfg_q.out_max})
                     ? cfg_q.out_max : raised[FREQ_W-1:0];

  assign push_o = start_i & ~q_status_i.full;
  assign cfg_o  = cfg_q;

endmodule

[src/pds_queue.sv]
// ----------------------------------------------------------------------------
// pds_queue
// Short request queue between the front and the search engine.
// ----------------------------------------------------------------------------
module pds_queue import pds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [FREQ_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [FREQ_W-1:0] pop_data_o,
  output queue_status_t     status_o
);

  logic [FREQ_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign do_push = push_i & (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop_i & (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

endmodule

[src/pds_back.sv]
// ----------------------------------------------------------------------------
// pds_back
// Search engine: walks N, M and P with a bit-serial divider.
// ----------------------------------------------------------------------------
module pds_back import pds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  queue_status_t     q_status_i,
  input  logic [FREQ_W-1:0] pop_data_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [N_W-1:0]    n_value_o,
  output logic [M_W-1:0]    m_value_o,
  output logic [2:0]        p_code_o,
  output logic [1:0]        s_band_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_PSCAN = 6'b010000,
    ST_NEXT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [FREQ_W-1:0]    req_q, best_err_q, best_vco_q;
  logic [N_W-1:0]       n_q, rn_q;
  logic [M_W-1:0]       m_q, rm_q;
  logic [P_W-1:0]       p_q;
  logic [2:0]           rp_q;
  logic [1:0]           rs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [D_W-1:0]       rem_q;
  logic [NUM_W-1:0]     dvd_q;

  logic              done_q;
  logic [N_W-1:0]    n_out_q;
  logic [M_W-1:0]    m_out_q;
  logic [2:0]        p_out_q;
  logic [1:0]        s_out_q;

  logic [NUM_W-1:0]  product;
  logic [D_W-1:0]    divisor;
  logic [D_W:0]      trial;
  logic              q_bit;
  logic [D_W-1:0]    trial_sub;
  logic [NUM_W-1:0]  f_val, err;
  logic              in_window, take, tie, last_pair;

  assign product   = NUM_W'(cfg_i.ref_clock) * NUM_W'({1'b0, n_q} + 8'd1);
  assign divisor   = {1'b0, m_q} + 1'b1;
  assign trial     = {rem_q, dvd_q[NUM_W-1]};
  assign q_bit     = (trial >= {1'b0, divisor});
  assign trial_sub = trial[D_W-1:0] - divisor;

  // dvd_q holds the quotient once the divider has finished.
  assign in_window = (dvd_q >= NUM_W'(cfg_i.vco_min)) && (dvd_q <= NUM_W'(cfg_i.vco_max));
  assign f_val     = dvd_q >> p_q;
  assign err       = (f_val < NUM_W'(req_q)) ? NUM_W'(req_q) - f_val : f_val - NUM_W'(req_q);
  assign take      = (err <= NUM_W'(best_err_q));
  assign tie       = (err == NUM_W'(best_err_q));
  assign last_pair = (m_q == M_LAST) && (n_q == N_LAST);

  assign pop_o = (state_q == ST_IDLE) && !q_status_i.empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (!q_status_i.empty) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_CHECK;
      ST_CHECK: state_d = in_window ? ST_PSCAN : ST_NEXT;
      ST_PSCAN: if (p_q == P_LAST) state_d = ST_NEXT;
      ST_NEXT:  state_d = last_pair ? ST_IDLE : ST_LOAD;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_NEXT) && last_pair;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        req_q      <= pop_data_i;
        best_err_q <= cfg_i.out_max;
        best_vco_q <= cfg_i.vco_max;
        rn_q       <= '0;
        rm_q       <= '0;
        rp_q       <= '0;
        rs_q       <= '0;
        n_q        <= N_FIRST;
        m_q        <= '0;
      end
      ST_LOAD: begin
        dvd_q <= product;
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= q_bit ? trial_sub : trial[D_W-1:0];
        dvd_q <= {dvd_q[NUM_W-2:0], q_bit};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_CHECK: begin
        p_q <= '0;
      end
      ST_PSCAN: begin
        // The best error is rewritten even when a tie loses on VCO value.
        if (take) begin
          best_err_q <= err[FREQ_W-1:0];
          if (!(tie && (dvd_q[FREQ_W-1:0] >= best_vco_q))) begin
            best_vco_q <= dvd_q[FREQ_W-1:0];
            rn_q       <= n_q;
            rm_q       <= m_q;
            rp_q       <= 3'((4'd1 << p_q) - 4'd1);
            rs_q       <= band_of(dvd_q[FREQ_W-1:0]);
          end
        end
        p_q <= p_q + 1'b1;
      end
      ST_NEXT: begin
        if (m_q == M_LAST) begin
          m_q <= '0;
          n_q <= n_q + 1'b1;
        end else begin
          m_q <= m_q + 1'b1;
        end
        if (last_pair) begin
          n_out_q <= rn_q;
          m_out_q <= rm_q;
          p_out_q <= rp_q;
          s_out_q <= rs_q;
        end
      end
      default: ;
    endcase
  end

  assign done_o    = done_q;
  assign n_value_o = n_out_q;
  assign m_value_o = m_out_q;
  assign p_code_o  = p_out_q;
  assign s_band_o  = s_out_q;

endmodule

[src/pll_divider_search.sv]
// ----------------------------------------------------------------------------
// pll_divider_search
// PLL N/M/P divider and loop-filter band search for a requested clock.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start_i high and busy_o low.
// The front clamps request_khz_i to the output window and places it in a
// two-entry queue; busy_o is high while that queue is full.
// The search engine walks N = 100..127, M = 0..31 and, for each VCO value
// inside the window, P = 0..3. Every (N, M) pair goes through load, 23
// steps of the one-bit-per-cycle divider, window check and advance, with
// the P scan between check and advance when the VCO value is in the
// window. The result appears in the cycle after the advance of the last
// pair. Queued requests start right after the previous one finishes.
// done_o is high for exactly one cycle with n_value_o, m_value_o, p_code_o
// and s_band_o; the receiver cannot stall, the fields hold until the next
// result. Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i;
// the user must write it only while idle (not enforced). Reset restores the
// default register values and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pll_divider_search import pds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [REQ_W-1:0]  request_khz_i,
  output logic              done_o,
  output logic [N_W-1:0]    n_value_o,
  output logic [M_W-1:0]    m_value_o,
  output logic [2:0]        p_code_o,
  output logic [1:0]        s_band_o
);

  cfg_t              cfg;
  queue_status_t     q_status;
  logic              push, pop;
  logic [FREQ_W-1:0] push_data, pop_data;

  pds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .request_khz_i (request_khz_i),
    .q_status_i    (q_status),
    .cfg_o         (cfg),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  pds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  pds_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_status_i (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .done_o     (done_o),
    .n_value_o  (n_value_o),
    .m_value_o  (m_value_o),
    .p_code_o   (p_code_o),
    .s_band_o   (s_band_o)
  );

  assign busy_o = q_status.full;

endmodule

[src/pds_checker.sv]
// ----------------------------------------------------------------------------
// pds_checker
// Port-level assertions for the PLL divider search block.
// ----------------------------------------------------------------------------
`include "pll_divider_search_assert.svh"

module pds_checker import pds_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [ADDR_W-1:0] cfg_addr_i,
  input logic [CFG_W-1:0]  cfg_wdata_i,
  input logic              start_i,
  input logic              busy_o,
  input logic [REQ_W-1:0]  request_khz_i,
  input logic              done_o,
  input logic [N_W-1:0]    n_value_o,
  input logic [M_W-1:0]    m_value_o,
  input logic [2:0]        p_code_o,
  input logic [1:0]        s_band_o
);

  // A search walks every (N, M) pair, so results never come back to back.
  `PDS_ASSERT(a_done_single, done_o |=> !done_o, "done_o high for two cycles")

  // Either no candidate was found or N lies in the scanned range.
  `PDS_ASSERT_IMP(a_n_range, done_o, (n_value_o >= N_FIRST) || (n_value_o == '0 && m_value_o == '0 && p_code_o == '0 && s_band_o == '0), "result N outside scan range")

  `PDS_ASSERT_IMP(a_p_code, done_o, (p_code_o == 3'd0) || (p_code_o == 3'd1) || (p_code_o == 3'd3) || (p_code_o == 3'd7), "p_code is not a post divider code")

  // The queue fills only through a request taken in the cycle before.
  `PDS_ASSERT_IMP(a_busy_rise, $rose(busy_o), $past(start_i), "busy rose without a request")

endmodule

bind pll_divider_search pds_checker u_pds_checker (.*);

[tb/pll_divider_search_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_divider_search_tb
// Self-checking bench for the PLL N/M/P divider and loop-filter band search.
// A short table of directed requests and register writes comes first. Then
// random requests follow under a series of random register settings. Every
// accepted request is predicted by a behavioral divider search or a known table
// result; each done_o strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pll_divider_search_tb;
  import pds_pkg::*;

  localparam int QUIET_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 10;

  // Register indexes that have no register behind them.
  localparam logic [ADDR_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [ADDR_W-1:0] CFG_SPARE_MID   = 3'd6;
  localparam logic [ADDR_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [M_W-1:0] m;
    logic [2:0]     p_code;
    logic [1:0]     s_band;
  } divider_set_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [ADDR_W-1:0]  addr;
    logic [REQ_W-1:0]   value;
    logic               known;
    divider_set_t       result;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ADDR_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              start_i;
  logic              busy_o;
  logic [REQ_W-1:0]  request_khz_i;
  logic              done_o;
  logic [N_W-1:0]    n_value_o;
  logic [M_W-1:0]    m_value_o;
  logic [2:0]        p_code_o;
  logic [1:0]        s_band_o;

  // Bench copy of the configuration registers.
  logic [REF_W-1:0]  ref_clk_khz;
  logic [FREQ_W-1:0] vco_lo_khz;
  logic [FREQ_W-1:0] vco_hi_khz;
  logic [FREQ_W-1:0] out_lo_khz;
  logic [FREQ_W-1:0] out_hi_khz;

  divider_set_t expected_dividers[$];
  stim_row_t    stim_table[$];
  int           idle_pct;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  divider_set_t oldest;

  pll_divider_search i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .request_khz_i(request_khz_i),
    .done_o       (done_o),
    .n_value_o    (n_value_o),
    .m_value_o    (m_value_o),
    .p_code_o     (p_code_o),
    .s_band_o     (s_band_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Full scan of N, M and P, keeping the closest candidate with the
  // lower-VCO tie break.
  function automatic divider_set_t search_dividers(input logic [REQ_W-1:0] req);
    divider_set_t best;
    logic [31:0]  target;
    logic [31:0]  best_err;
    logic [31:0]  best_vco;
    logic [31:0]  vco;
    logic [31:0]  freq;
    logic [31:0]  err;
    logic         tie;
    target = 32'(req);
    if (target < 32'(out_lo_khz)) target = 32'(out_lo_khz);
    if (target > 32'(out_hi_khz)) target = 32'(out_hi_khz);
    best     = '0;
    best_err = 32'(out_hi_khz);
    best_vco = 32'(vco_hi_khz);
    for (int n = int'(N_FIRST); n <= int'(N_LAST); n++) begin
      for (int m = 0; m <= int'(M_LAST); m++) begin
        vco = (32'(ref_clk_khz) * 32'(n + 1)) / 32'(m + 1);
        if (vco < 32'(vco_lo_khz) || vco > 32'(vco_hi_khz)) continue;
        for (int p = 0; p <= int'(P_LAST); p++) begin
          freq = vco >> p;
          err  = (freq < target) ? target - freq : freq - target;
          if (err > best_err) continue;
          // The error is taken over even when the tie is then rejected.
          tie      = (err == best_err);
          best_err = err;
          if (tie && vco >= best_vco) continue;
          best_vco      = vco;
          best.n        = N_W'(n);
          best.m        = M_W'(m);
          best.p_code   = 3'((1 << p) - 1);
          if (vco <= 32'(BAND1_KHZ)) begin
            best.s_band = 2'd0;
          end else if (vco <= 32'(BAND2_KHZ)) begin
            best.s_band = 2'd1;
          end else if (vco <= 32'(BAND3_KHZ)) begin
            best.s_band = 2'd2;
          end else begin
            best.s_band = 2'd3;
          end
        end
      end
    end
    return best;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (addr)
      CFG_REF_CLOCK: ref_clk_khz = data[REF_W-1:0];
      CFG_VCO_MIN:   vco_lo_khz  = data;
      CFG_VCO_MAX:   vco_hi_khz  = data;
      CFG_OUT_MIN:   out_lo_khz  = data;
      CFG_OUT_MAX:   out_hi_khz  = data;
      default: ;
    endcase
  endtask

  // Registers change only once every pending request has produced its result.
  task automatic drain();
    start_i = 1'b0;
    while (expected_dividers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_request(input logic [REQ_W-1:0] req, input logic known,
                              input divider_set_t result);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i       = 1'b1;
    request_khz_i = req;
    do @(posedge clk_i); while (busy_o);
    expected_dividers.push_back(known ? result : search_dividers(req));
    @(negedge clk_i);
  endtask

  task automatic add_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    stim_table.push_back('{kind: ROW_WRITE, addr: addr, value: REQ_W'(data),
                           known: 1'b0, result: '0});
  endtask

  task automatic add_request(input logic [REQ_W-1:0] req);
    stim_table.push_back('{kind: ROW_REQUEST, addr: '0, value: req, known: 1'b0,
                           result: '0});
  endtask

  task automatic add_known(input logic [REQ_W-1:0] req, input divider_set_t result);
    stim_table.push_back('{kind: ROW_REQUEST, addr: '0, value: req, known: 1'b1,
                           result: result});
  endtask

  task automatic pick_setting();
    logic [FREQ_W-1:0] lo;
    logic [FREQ_W-1:0] hi;
    int                choice;
    choice = $urandom_range(0, 9);
    if (choice < 7) begin
      write_reg(CFG_REF_CLOCK, CFG_W'($urandom_range(1000, 30000)));
      lo = FREQ_W'($urandom_range(0, 120000));
      hi = FREQ_W'($urandom_range(lo, 262143));
      write_reg(CFG_VCO_MIN, lo);
      write_reg(CFG_VCO_MAX, hi);
      lo = FREQ_W'($urandom_range(0, 30000));
      hi = FREQ_W'($urandom_range(lo, 262143));
      write_reg(CFG_OUT_MIN, lo);
      write_reg(CFG_OUT_MAX, hi);
    end else if (choice < 9) begin
      // Raw values: empty or crossed windows and masked reference bits.
      write_reg(CFG_REF_CLOCK, CFG_W'($urandom));
      write_reg(CFG_VCO_MIN, CFG_W'($urandom));
      write_reg(CFG_VCO_MAX, CFG_W'($urandom));
      write_reg(CFG_OUT_MIN, CFG_W'($urandom));
      write_reg(CFG_OUT_MAX, CFG_W'($urandom));
    end else begin
      write_reg(CFG_REF_CLOCK, 18'd14318);
      write_reg(CFG_VCO_MIN, 18'd50000);
      write_reg(CFG_VCO_MAX, 18'd220000);
      write_reg(CFG_OUT_MIN, 18'd6262);
      write_reg(CFG_OUT_MAX, 18'd218864);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(ADDR_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), CFG_W'($urandom));
    end
  endtask

  function automatic logic [REQ_W-1:0] pick_request();
    int choice;
    choice = $urandom_range(0, 19);
    if (choice < 12 && out_lo_khz <= out_hi_khz) begin
      return REQ_W'($urandom_range(out_lo_khz, out_hi_khz));
    end else if (choice < 17) begin
      return REQ_W'($urandom_range(0, 20'hFFFFF));
    end
    // Close to one of the clamp limits.
    return REQ_W'(($urandom_range(0, 1) ? out_lo_khz : out_hi_khz) + $urandom_range(0, 4) - 2);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request or result for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
      if (done_o) begin
        if (expected_dividers.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual n %0d m %0d p %0d s %0d",
                   $time, n_value_o, m_value_o, p_code_o, s_band_o);
          mismatches++;
        end else begin
          oldest = expected_dividers.pop_front();
          check_field("n_value", oldest.n, n_value_o);
          check_field("m_value", oldest.m, m_value_o);
          check_field("p_code", oldest.p_code, p_code_o);
          check_field("s_band", oldest.s_band, s_band_o);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    start_i       = 1'b0;
    request_khz_i = '0;
    idle_pct      = 0;
    ref_clk_khz   = 16'd14318;
    vco_lo_khz    = 18'd50000;
    vco_hi_khz    = 18'd220000;
    out_lo_khz    = 18'd6262;
    out_hi_khz    = 18'd218864;

    // Reset settings, clamp limits and a few common pixel clocks.
    add_request(20'd0);
    add_request(20'hFFFFF);
    add_request(20'd6262);
    add_request(20'd218864);
    add_request(20'd25175);
    add_request(20'd65000);
    add_request(20'd108000);
    // Empty VCO window: no candidate, all fields zero.
    add_write(CFG_VCO_MIN, 18'd1);
    add_write(CFG_VCO_MAX, 18'd0);
    add_known(20'd50000, '0);
    add_known(20'hFFFFF, '0);
    // Zero reference clock with open windows: the first pair wins at P = 0.
    add_write(CFG_REF_CLOCK, 18'd0);
    add_write(CFG_VCO_MIN, 18'd0);
    add_write(CFG_VCO_MAX, 18'h3FFFF);
    add_write(CFG_OUT_MIN, 18'd0);
    add_write(CFG_OUT_MAX, 18'h3FFFF);
    add_known(20'd0, '{n: 7'd100, m: 5'd0, p_code: 3'd0, s_band: 2'd0});
    add_known(20'hFFFFF, '{n: 7'd100, m: 5'd0, p_code: 3'd0, s_band: 2'd0});
    // Zero reference clock below the VCO window.
    add_write(CFG_VCO_MIN, 18'd1);
    add_known(20'd1, '0);
    // Largest reference clock; the upper data bits are dropped.
    add_write(CFG_REF_CLOCK, 18'h3FFFF);
    add_write(CFG_VCO_MIN, 18'd0);
    add_request(20'd0);
    add_request(20'h3FFFF);
    add_request(20'd131072);
    // Smallest nonzero reference clock.
    add_write(CFG_REF_CLOCK, 18'd1);
    add_request(20'd0);
    add_request(20'd3);
    // Crossed output window: the request always lands on the upper clamp.
    add_write(CFG_REF_CLOCK, 18'd14318);
    add_write(CFG_VCO_MIN, 18'd50000);
    add_write(CFG_VCO_MAX, 18'd220000);
    add_write(CFG_OUT_MIN, 18'd200000);
    add_write(CFG_OUT_MAX, 18'd1000);
    add_request(20'd0);
    add_request(20'hFFFFF);
    // Writes to unused indexes must not disturb any register.
    add_write(CFG_OUT_MIN, 18'd6262);
    add_write(CFG_OUT_MAX, 18'd218864);
    add_write(CFG_SPARE_FIRST, 18'h3FFFF);
    add_write(CFG_SPARE_MID, 18'h3FFFF);
    add_write(CFG_SPARE_LAST, 18'h3FFFF);
    add_request(20'd100000);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        drain();
        write_reg(stim_table[i].addr, CFG_W'(stim_table[i].value));
      end else begin
        send_request(stim_table[i].value, stim_table[i].known, stim_table[i].result);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      pick_setting();
      idle_pct = (phase < 4) ? 38 : (phase < 7) ? 69 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request(pick_request(), 1'b0, '0);
      end
    end

    start_i = 1'b0;
    while (expected_dividers.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/pds_pkg.sv
src/pds_front.sv
src/pds_queue.sv
src/pds_back.sv
src/pll_divider_search.sv
src/pds_checker.sv
tb/pll_divider_search_tb.sv
